FILE: rtl/olc_pkg.sv
// Shared codes, defaults and the outcode function of the outcode line clipper.
// No dependencies; olc_cfg_if, olc_pass and outcode_line_clipper_unit import this package.
package olc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_PASSES_DEF = 4;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [3:0] CODE_TOP    = 4'd8;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_LEFT   = 4'd1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEFT   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RIGHT  = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TOP    = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_BOTTOM = 8'd3;

  localparam int WINDOW_LEFT_RST   = -120;
  localparam int WINDOW_RIGHT_RST  = 120;
  localparam int WINDOW_TOP_RST    = 120;
  localparam int WINDOW_BOTTOM_RST = -120;

  function automatic logic [3:0] outcode(input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [31:0] wl,
                                         input logic signed [31:0] wr,
                                         input logic signed [31:0] wt,
                                         input logic signed [31:0] wb);
    logic [3:0] c;
    c = 4'd0;
    if (y > wt) c = c | CODE_TOP;
    else if (y < wb) c = c | CODE_BOTTOM;
    if (x > wr) c = c | CODE_RIGHT;
    else if (x < wl) c = c | CODE_LEFT;
    return c;
  endfunction

endpackage

FILE: rtl/olc_seg_if.sv
// Segment request channel: valid, ready and the two endpoints.
// Does not depend on olc_pkg; width is a parameter.
interface olc_seg_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

FILE: rtl/olc_clip_if.sv
// Clip result channel: valid, ready, accept flag and the clipped endpoints.
// Width is a parameter; no other dependencies.
interface olc_clip_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic accepted;
  logic signed [W-1:0] clipped_start_x;
  logic signed [W-1:0] clipped_start_y;
  logic signed [W-1:0] clipped_end_x;
  logic signed [W-1:0] clipped_end_y;
  modport source (output valid, accepted, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, input ready);
  modport sink (input valid, accepted, clipped_start_x, clipped_start_y,
                clipped_end_x, clipped_end_y, output ready);
endinterface

FILE: rtl/olc_cfg_if.sv
// Configuration write channel: valid, ready, register index and data.
// Index width comes from olc_pkg.
interface olc_cfg_if import olc_pkg::*; #(parameter int W = 16);
  logic valid;
  logic ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/olc_pass.sv
// One clipping pass: outcode test, edge select, multiply, bit-per-stage
// divide and the endpoint move. Uses olc_pkg for codes and outcode().
module olc_pass import olc_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic signed [W-1:0] wl,
  input  logic signed [W-1:0] wr,
  input  logic signed [W-1:0] wt,
  input  logic signed [W-1:0] wb,
  input  logic                in_valid,
  input  logic                in_active,
  input  logic                in_acc,
  input  logic signed [W-1:0] in_x0,
  input  logic signed [W-1:0] in_y0,
  input  logic signed [W-1:0] in_x1,
  input  logic signed [W-1:0] in_y1,
  output logic                out_valid,
  output logic                out_active,
  output logic                out_acc,
  output logic signed [W-1:0] out_x0,
  output logic signed [W-1:0] out_y0,
  output logic signed [W-1:0] out_x1,
  output logic signed [W-1:0] out_y1
);

  localparam int P = 2 * W + 1;
  localparam int R = W + 2;
  localparam int B = 2 * W + 3;
  localparam logic signed [B-1:0] SAT_HI = B'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [B-1:0] SAT_LO = -SAT_HI - B'(1);

  typedef struct packed {
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] edge_v;
    logic signed [W-1:0] p0;
    logic                active;
    logic                acc;
    logic                move;
    logic                sel1;
    logic                movex;
    logic                neg;
    logic                dz;
  } ctx_t;

  ctx_t              ctx_q [0:P+1];
  logic              valid_q [0:P+1];
  logic [W:0]        den_q [0:P+1];
  logic [W:0]        mdp;
  logic [W:0]        mnum;
  logic [P-1:0]      dvd_q [1:P+1];
  logic [P-1:0]      quo_q [1:P+1];
  logic [R-1:0]      rem_q [1:P+1];

  ctx_t                a_next;
  logic [W:0]          a_mdp;
  logic [W:0]          a_mnum;
  logic [W:0]          a_den;
  logic [3:0]          c0;
  logic [3:0]          c1;
  logic [3:0]          co;
  logic signed [W:0]   dp;
  logic signed [W:0]   num;
  logic signed [W:0]   den;

  always_comb begin
    a_next = '0;
    a_next.x0 = in_x0;
    a_next.y0 = in_y0;
    a_next.x1 = in_x1;
    a_next.y1 = in_y1;
    a_next.active = in_active;
    a_next.acc = in_acc;
    c0 = outcode(32'(in_x0), 32'(in_y0), 32'(wl), 32'(wr), 32'(wt), 32'(wb));
    c1 = outcode(32'(in_x1), 32'(in_y1), 32'(wl), 32'(wr), 32'(wt), 32'(wb));
    if (in_active) begin
      if (c0 == 4'd0 && c1 == 4'd0) begin
        a_next.acc = 1'b1;
        a_next.active = 1'b0;
      end else if ((c0 & c1) != 4'd0) begin
        a_next.active = 1'b0;
      end
    end
    a_next.move = a_next.active;
    a_next.sel1 = (c0 == 4'd0);
    co = (c0 != 4'd0) ? c0 : c1;
    priority if ((co & CODE_TOP) != 4'd0) begin
      a_next.movex = 1'b1;
      a_next.edge_v = wt;
    end else if ((co & CODE_BOTTOM) != 4'd0) begin
      a_next.movex = 1'b1;
      a_next.edge_v = wb;
    end else if ((co & CODE_RIGHT) != 4'd0) begin
      a_next.movex = 1'b0;
      a_next.edge_v = wr;
    end else begin
      a_next.movex = 1'b0;
      a_next.edge_v = wl;
    end
    if (a_next.movex) begin
      a_next.p0 = in_x0;
      dp  = (W+1)'(in_x1) - (W+1)'(in_x0);
      num = (W+1)'(a_next.edge_v) - (W+1)'(in_y0);
      den = (W+1)'(in_y1) - (W+1)'(in_y0);
    end else begin
      a_next.p0 = in_y0;
      dp  = (W+1)'(in_y1) - (W+1)'(in_y0);
      num = (W+1)'(a_next.edge_v) - (W+1)'(in_x0);
      den = (W+1)'(in_x1) - (W+1)'(in_x0);
    end
    a_next.neg = dp[W] ^ num[W] ^ den[W];
    a_next.dz = (den == '0);
    a_mdp  = dp[W] ? (W+1)'(-dp) : (W+1)'(dp);
    a_mnum = num[W] ? (W+1)'(-num) : (W+1)'(num);
    a_den  = den[W] ? (W+1)'(-den) : (W+1)'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
      valid_q[1] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
      valid_q[1] <= valid_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_q[0] <= a_next;
      den_q[0] <= a_den;
      mdp      <= a_mdp;
      mnum     <= a_mnum;
      ctx_q[1] <= ctx_q[0];
      den_q[1] <= den_q[0];
      dvd_q[1] <= P'(mdp) * P'(mnum);
      quo_q[1] <= '0;
      rem_q[1] <= '0;
    end
  end

  for (genvar k = 0; k < P; k++) begin : g_div
    logic [R-1:0] t;
    logic         ge;
    always_comb begin
      t  = {rem_q[k+1][R-2:0], dvd_q[k+1][P-1]};
      ge = (t >= {1'b0, den_q[k+1]});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+2] <= 1'b0;
      end else if (en) begin
        valid_q[k+2] <= valid_q[k+1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ctx_q[k+2] <= ctx_q[k+1];
        den_q[k+2] <= den_q[k+1];
        dvd_q[k+2] <= {dvd_q[k+1][P-2:0], 1'b0};
        quo_q[k+2] <= {quo_q[k+1][P-2:0], ge};
        rem_q[k+2] <= ge ? R'(t - {1'b0, den_q[k+1]}) : t;
      end
    end
  end

  ctx_t                f_ctx;
  ctx_t                f_next;
  logic signed [B-1:0] base;
  logic signed [B-1:0] pw;
  logic signed [B-1:0] mw;
  logic                frac;
  logic signed [W-1:0] cross_v;

  always_comb begin
    f_ctx  = ctx_q[P+1];
    f_next = f_ctx;
    pw   = B'(f_ctx.p0);
    mw   = $signed(B'(quo_q[P+1]));
    frac = (rem_q[P+1] != '0);
    if (!f_ctx.neg) begin
      base = pw + mw;
      if (frac && base < 0) base = base + B'(1);
    end else begin
      base = pw - mw;
      if (frac && base > 0) base = base - B'(1);
    end
    priority if (f_ctx.dz) cross_v = f_ctx.p0;
    else if (base > SAT_HI) cross_v = SAT_HI[W-1:0];
    else if (base < SAT_LO) cross_v = SAT_LO[W-1:0];
    else cross_v = base[W-1:0];
    if (f_ctx.move) begin
      if (f_ctx.sel1) begin
        f_next.x1 = f_ctx.movex ? cross_v : f_ctx.edge_v;
        f_next.y1 = f_ctx.movex ? f_ctx.edge_v : cross_v;
      end else begin
        f_next.x0 = f_ctx.movex ? cross_v : f_ctx.edge_v;
        f_next.y0 = f_ctx.movex ? f_ctx.edge_v : cross_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_q[P+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_active <= f_next.active;
      out_acc    <= f_next.acc;
      out_x0     <= f_next.x0;
      out_y0     <= f_next.y0;
      out_x1     <= f_next.x1;
      out_y1     <= f_next.y1;
    end
  end

endmodule

FILE: rtl/outcode_line_clipper_unit.sv
// Outcode line clipper: window registers, a chain of clipping passes and
// the final accept test. Uses olc_pkg, the channel interfaces and olc_pass.
// Throughput: one segment per cycle; each pass is a multiply followed by a
// divider that resolves one quotient bit per stage, and the whole pipeline
// holds while the output register waits. Synchronous active-high reset
// clears valid bits and loads the window registers with their reset values.
module outcode_line_clipper_unit import olc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_PASSES = MAX_PASSES_DEF
) (
  input logic       clk,
  input logic       rst,
  olc_seg_if.sink   seg_in,
  olc_clip_if.source clip_out,
  olc_cfg_if.sink   cfg
);

  localparam int W = COORD_BITS;

  logic signed [W-1:0] wl;
  logic signed [W-1:0] wr;
  logic signed [W-1:0] wt;
  logic signed [W-1:0] wb;
  logic                en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wl <= W'(WINDOW_LEFT_RST);
      wr <= W'(WINDOW_RIGHT_RST);
      wt <= W'(WINDOW_TOP_RST);
      wb <= W'(WINDOW_BOTTOM_RST);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WINDOW_LEFT:   wl <= $signed(cfg.data);
        REG_WINDOW_RIGHT:  wr <= $signed(cfg.data);
        REG_WINDOW_TOP:    wt <= $signed(cfg.data);
        REG_WINDOW_BOTTOM: wb <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  assign en = !clip_out.valid || clip_out.ready;
  assign seg_in.ready = en;

  logic                v_c [0:MAX_PASSES];
  logic                act_c [0:MAX_PASSES];
  logic                acc_c [0:MAX_PASSES];
  logic signed [W-1:0] x0_c [0:MAX_PASSES];
  logic signed [W-1:0] y0_c [0:MAX_PASSES];
  logic signed [W-1:0] x1_c [0:MAX_PASSES];
  logic signed [W-1:0] y1_c [0:MAX_PASSES];

  assign v_c[0]   = seg_in.valid;
  assign act_c[0] = 1'b1;
  assign acc_c[0] = 1'b0;
  assign x0_c[0]  = seg_in.start_x;
  assign y0_c[0]  = seg_in.start_y;
  assign x1_c[0]  = seg_in.end_x;
  assign y1_c[0]  = seg_in.end_y;

  for (genvar i = 0; i < MAX_PASSES; i++) begin : g_pass
    olc_pass #(.W(W)) u_pass (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .wl         (wl),
      .wr         (wr),
      .wt         (wt),
      .wb         (wb),
      .in_valid   (v_c[i]),
      .in_active  (act_c[i]),
      .in_acc     (acc_c[i]),
      .in_x0      (x0_c[i]),
      .in_y0      (y0_c[i]),
      .in_x1      (x1_c[i]),
      .in_y1      (y1_c[i]),
      .out_valid  (v_c[i+1]),
      .out_active (act_c[i+1]),
      .out_acc    (acc_c[i+1]),
      .out_x0     (x0_c[i+1]),
      .out_y0     (y0_c[i+1]),
      .out_x1     (x1_c[i+1]),
      .out_y1     (y1_c[i+1])
    );
  end

  logic [3:0] c0;
  logic [3:0] c1;
  logic       acc_f;

  always_comb begin
    c0 = outcode(32'(x0_c[MAX_PASSES]), 32'(y0_c[MAX_PASSES]),
                 32'(wl), 32'(wr), 32'(wt), 32'(wb));
    c1 = outcode(32'(x1_c[MAX_PASSES]), 32'(y1_c[MAX_PASSES]),
                 32'(wl), 32'(wr), 32'(wt), 32'(wb));
    acc_f = acc_c[MAX_PASSES] ||
            (act_c[MAX_PASSES] && c0 == 4'd0 && c1 == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_out.valid <= 1'b0;
    end else if (en) begin
      clip_out.valid <= v_c[MAX_PASSES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_out.accepted        <= acc_f;
      clip_out.clipped_start_x <= acc_f ? x0_c[MAX_PASSES] : '0;
      clip_out.clipped_start_y <= acc_f ? y0_c[MAX_PASSES] : '0;
      clip_out.clipped_end_x   <= acc_f ? x1_c[MAX_PASSES] : '0;
      clip_out.clipped_end_y   <= acc_f ? y1_c[MAX_PASSES] : '0;
    end
  end

endmodule
